[src/acl_expression_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// acl_expression_tokenizer_defines.svh
// Assertion macros for the expression tokenizer. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ACL_EXPRESSION_TOKENIZER_DEFINES_SVH
`define ACL_EXPRESSION_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define AET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property at every edge, reset included
`define AET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AET_ASSERT(lbl, prop, msg)
`define AET_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/aet_pkg.sv]
// ----------------------------------------------------------------------------
// aet_pkg
// Shared types, token codes, character constants and classification
// functions for the expression tokenizer.
// ----------------------------------------------------------------------------
package aet_pkg;

  // default width of the character position counters
  localparam int POS_BITS_DEFAULT = 16;

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNTERM     = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

  // token types
  localparam logic [4:0] TT_END     = 5'd0;
  localparam logic [4:0] TT_IDENT   = 5'd1;
  localparam logic [4:0] TT_KW_BASE = 5'd2;
  localparam logic [4:0] TT_LPAREN  = 5'd12;
  localparam logic [4:0] TT_RPAREN  = 5'd13;
  localparam logic [4:0] TT_COMMA   = 5'd14;
  localparam logic [4:0] TT_EQ      = 5'd15;
  localparam logic [4:0] TT_NE      = 5'd16;
  localparam logic [4:0] TT_GT      = 5'd17;
  localparam logic [4:0] TT_GE      = 5'd18;
  localparam logic [4:0] TT_LT      = 5'd19;
  localparam logic [4:0] TT_LE      = 5'd20;
  localparam logic [4:0] TT_STRING  = 5'd21;
  localparam logic [4:0] TT_NUMBER  = 5'd22;

  // characters with a meaning of their own
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // keywords, packed right-aligned, lower case
  localparam int KW_COUNT = 10;
  localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
    40'h00_7472_7565,   // true
    40'h66_616C_7365,   // false
    40'h00_0061_6E64,   // and
    40'h00_0000_6F72,   // or
    40'h00_006E_6F74,   // not
    40'h00_6C69_6B65,   // like
    40'h6D_6174_6368,   // match
    40'h00_0000_696E,   // in
    40'h00_0061_6E79,   // any
    40'h00_0061_6C6C    // all
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{
    16'd4, 16'd5, 16'd3, 16'd2, 16'd3, 16'd4, 16'd5, 16'd2, 16'd3, 16'd3
  };
  localparam logic [15:0] KW_MAX_LEN = 16'd5;

  typedef enum logic [3:0] {
    LEX_IDLE,
    LEX_IDENT,
    LEX_NUMBER,
    LEX_EQ,
    LEX_BANG,
    LEX_GT,
    LEX_LT,
    LEX_STRING,
    LEX_ESC,
    LEX_DROP
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } char_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  token_type;
    logic [1:0]  error_code;
    logic [15:0] start_pos;
    logic [15:0] raw_length;
    logic [7:0]  content_char;
    logic        last_result;
  } tok_item_t;

  // results of one accepted item, in order
  typedef struct packed {
    logic [1:0]           count;
    tok_item_t [1:0]      item;
  } res_pair_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return is_letter(c) || (c == CH_UNDER);
  endfunction

  function automatic logic ident_part(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DASH);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
  endfunction

  // keyword lookup over the five-character window
  function automatic logic [4:0] ident_type(input logic [39:0] kw,
                                            input logic [15:0] len);
    logic [4:0] t;
    t = TT_IDENT;
    if (len <= KW_MAX_LEN) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if ((KW_LEN[k] == len) && (KW_TEXT[k] == kw)) t = TT_KW_BASE + 5'(k);
      end
    end
    return t;
  endfunction

  function automatic tok_item_t mk_res(input logic [1:0] kind, input logic [4:0] ttype,
                                       input logic [1:0] err, input logic [15:0] pos,
                                       input logic [15:0] len, input logic [7:0] cc);
    tok_item_t r;
    r.result_kind  = kind;
    r.token_type   = ttype;
    r.error_code   = err;
    r.start_pos    = pos;
    r.raw_length   = len;
    r.content_char = cc;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

[src/aet_lex_core.sv]
// ----------------------------------------------------------------------------
// aet_lex_core
// Lexer state and single-pass result logic: takes one accepted character or
// terminator and produces up to two results plus the next lexer state.
// ----------------------------------------------------------------------------
module aet_lex_core #(
  parameter int POS_BITS = aet_pkg::POS_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  aet_pkg::char_item_t item,
  output aet_pkg::res_pair_t  pair
);
  import aet_pkg::*;

  // lexer state
  lex_mode_t           mode, mode_next;
  logic [POS_BITS-1:0] char_index, char_index_next;
  logic [POS_BITS-1:0] token_start, token_start_next;
  logic [39:0]         keyword_window, keyword_window_next;
  logic [15:0]         word_length, word_length_next;

  logic [7:0]           c;
  logic [POS_BITS+15:0] idx_ext, start_ext;
  logic [15:0]          idx16, start16, len_inc;

  // what a character starting a fresh token does
  lex_mode_t f_mode;
  logic      f_emit, f_start, f_len_one, f_kw_set;
  tok_item_t f_res;

  // primary and follow-on results of this item
  logic      a_emit, b_emit;
  tok_item_t a_res, b_res;
  tok_item_t r0, r1;
  logic [1:0] n;

  assign c         = item.char_code;
  assign idx_ext   = {16'b0, char_index};
  assign start_ext = {16'b0, token_start};
  assign idx16     = idx_ext[15:0];
  assign start16   = start_ext[15:0];
  assign len_inc   = (word_length == 16'hFFFF) ? word_length : word_length + 16'd1;

  // classify a character that opens a new token
  always_comb begin
    f_mode    = LEX_IDLE;
    f_emit    = 1'b0;
    f_start   = 1'b0;
    f_len_one = 1'b0;
    f_kw_set  = 1'b0;
    f_res     = mk_res(KIND_TOKEN, TT_END, ERR_NONE, idx16, 16'd1, 8'd0);
    if (!is_space(c)) begin
      if (c == CH_LPAREN) begin
        f_emit = 1'b1;
        f_res.token_type = TT_LPAREN;
      end else if (c == CH_RPAREN) begin
        f_emit = 1'b1;
        f_res.token_type = TT_RPAREN;
      end else if (c == CH_COMMA) begin
        f_emit = 1'b1;
        f_res.token_type = TT_COMMA;
      end else if (c == CH_EQUAL) begin
        f_mode  = LEX_EQ;
        f_start = 1'b1;
      end else if (c == CH_BANG) begin
        f_mode  = LEX_BANG;
        f_start = 1'b1;
      end else if (c == CH_GREAT) begin
        f_mode  = LEX_GT;
        f_start = 1'b1;
      end else if (c == CH_LESS) begin
        f_mode  = LEX_LT;
        f_start = 1'b1;
      end else if (c == CH_QUOTE) begin
        f_mode    = LEX_STRING;
        f_start   = 1'b1;
        f_len_one = 1'b1;
      end else if (is_digit(c)) begin
        f_mode    = LEX_NUMBER;
        f_start   = 1'b1;
        f_len_one = 1'b1;
        f_kw_set  = 1'b1;
      end else if (ident_start(c)) begin
        f_mode    = LEX_IDENT;
        f_start   = 1'b1;
        f_len_one = 1'b1;
        f_kw_set  = 1'b1;
      end else begin
        f_mode = LEX_DROP;
        f_emit = 1'b1;
        f_res  = mk_res(KIND_ERROR, TT_END, ERR_UNEXPECTED, idx16, 16'd0, 8'd0);
      end
    end
  end

  // step the lexer by one item
  always_comb begin
    mode_next           = mode;
    char_index_next     = char_index + POS_BITS'(1);
    token_start_next    = token_start;
    keyword_window_next = keyword_window;
    word_length_next    = word_length;
    a_emit = 1'b0;
    a_res  = mk_res(KIND_TOKEN, TT_END, ERR_NONE, start16, 16'd0, 8'd0);
    b_emit = 1'b0;
    b_res  = f_res;

    if (item.end_mark) begin
      // flush the pending token, then End unless an error closed things
      b_emit = 1'b1;
      b_res  = mk_res(KIND_TOKEN, TT_END, ERR_NONE, idx16, 16'd0, 8'd0);
      case (mode)
        LEX_IDENT: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_TOKEN, ident_type(keyword_window, word_length), ERR_NONE,
                          start16, word_length, 8'd0);
        end
        LEX_NUMBER: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_TOKEN, TT_NUMBER, ERR_NONE, start16, word_length, 8'd0);
        end
        LEX_GT: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_TOKEN, TT_GT, ERR_NONE, start16, 16'd1, 8'd0);
        end
        LEX_LT: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_TOKEN, TT_LT, ERR_NONE, start16, 16'd1, 8'd0);
        end
        LEX_EQ, LEX_BANG: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_ERROR, TT_END, ERR_UNEXPECTED, start16, 16'd0, 8'd0);
          b_emit = 1'b0;
        end
        LEX_STRING, LEX_ESC: begin
          a_emit = 1'b1;
          a_res  = mk_res(KIND_ERROR, TT_END, ERR_UNTERM, start16, 16'd0, 8'd0);
          b_emit = 1'b0;
        end
        LEX_DROP: begin
          b_emit = 1'b0;
        end
        default: begin
        end
      endcase
      // return to the reset state for the next expression
      mode_next           = LEX_IDLE;
      char_index_next     = '0;
      token_start_next    = '0;
      keyword_window_next = '0;
      word_length_next    = '0;
    end else begin
      case (mode)
        LEX_STRING: begin
          word_length_next = len_inc;
          if (c == CH_QUOTE) begin
            a_emit    = 1'b1;
            a_res     = mk_res(KIND_TOKEN, TT_STRING, ERR_NONE, start16, len_inc, 8'd0);
            mode_next = LEX_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_next = LEX_ESC;
          end else begin
            a_emit = 1'b1;
            a_res  = mk_res(KIND_CHAR, TT_END, ERR_NONE, start16, 16'd0, c);
          end
        end
        LEX_ESC: begin
          word_length_next = len_inc;
          a_emit    = 1'b1;
          a_res     = mk_res(KIND_CHAR, TT_END, ERR_NONE, start16, 16'd0, c);
          mode_next = LEX_STRING;
        end
        LEX_EQ, LEX_BANG: begin
          a_emit = 1'b1;
          if (c == CH_EQUAL) begin
            a_res = mk_res(KIND_TOKEN, (mode == LEX_EQ) ? TT_EQ : TT_NE, ERR_NONE,
                           start16, 16'd2, 8'd0);
            mode_next = LEX_IDLE;
          end else begin
            a_res     = mk_res(KIND_ERROR, TT_END, ERR_UNEXPECTED, start16, 16'd0, 8'd0);
            mode_next = LEX_DROP;
          end
        end
        LEX_GT, LEX_LT: begin
          a_emit = 1'b1;
          if (c == CH_EQUAL) begin
            a_res = mk_res(KIND_TOKEN, (mode == LEX_GT) ? TT_GE : TT_LE, ERR_NONE,
                           start16, 16'd2, 8'd0);
            mode_next = LEX_IDLE;
          end else begin
            a_res = mk_res(KIND_TOKEN, (mode == LEX_GT) ? TT_GT : TT_LT, ERR_NONE,
                           start16, 16'd1, 8'd0);
            b_emit = f_emit;
          end
        end
        LEX_IDENT: begin
          if (ident_part(c)) begin
            if (word_length < KW_MAX_LEN) begin
              keyword_window_next = {keyword_window[31:0], to_lower(c)};
            end
            word_length_next = len_inc;
          end else begin
            a_emit = 1'b1;
            a_res  = mk_res(KIND_TOKEN, ident_type(keyword_window, word_length), ERR_NONE,
                            start16, word_length, 8'd0);
            b_emit = f_emit;
          end
        end
        LEX_NUMBER: begin
          if (is_digit(c) || (c == CH_DOT)) begin
            word_length_next = len_inc;
          end else begin
            a_emit = 1'b1;
            a_res  = mk_res(KIND_TOKEN, TT_NUMBER, ERR_NONE, start16, word_length, 8'd0);
            b_emit = f_emit;
          end
        end
        LEX_DROP: begin
        end
        default: begin
          b_emit = f_emit;
        end
      endcase

      // hand over to the fresh-token logic where the old token closed
      if ((mode == LEX_IDLE) ||
          (((mode == LEX_GT) || (mode == LEX_LT)) && (c != CH_EQUAL)) ||
          ((mode == LEX_IDENT) && !ident_part(c)) ||
          ((mode == LEX_NUMBER) && !(is_digit(c) || (c == CH_DOT)))) begin
        mode_next = f_mode;
        if (f_start) token_start_next = char_index;
        if (f_len_one) word_length_next = 16'd1;
        if (f_kw_set) keyword_window_next = {32'b0, to_lower(c)};
      end
    end
  end

  // pack results in order and mark the final one
  always_comb begin
    n  = 2'({1'b0, a_emit} + {1'b0, b_emit});
    r0 = a_emit ? a_res : b_res;
    r1 = b_res;
    if (n == 2'd2) begin
      r1.last_result = 1'b1;
    end else begin
      r0.last_result = 1'b1;
    end
    pair.count   = accept ? n : 2'd0;
    pair.item[0] = r0;
    pair.item[1] = r1;
  end

  // hold state unless an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= LEX_IDLE;
      char_index     <= '0;
      token_start    <= '0;
      keyword_window <= '0;
      word_length    <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      char_index     <= char_index_next;
      token_start    <= token_start_next;
      keyword_window <= keyword_window_next;
      word_length    <= word_length_next;
    end
  end

endmodule

[src/aet_res_queue.sv]
// ----------------------------------------------------------------------------
// aet_res_queue
// Four-entry result queue: takes up to two results per cycle, presents one
// registered result per transfer, and stalls the input side when fewer than
// two slots are free.
// ----------------------------------------------------------------------------
`include "acl_expression_tokenizer_defines.svh"

module aet_res_queue (
  input  logic               clk,
  input  logic               rst,
  input  aet_pkg::res_pair_t pair,
  output logic               full,
  output logic               tok_valid,
  input  logic               tok_stall,
  output aet_pkg::tok_item_t tok_data
);
  import aet_pkg::*;

  tok_item_t         slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd, wr, wr_plus;
  logic [QCNT_W-1:0] count, level_in;
  logic              pop;
  logic              last_lo, last_hi;

  assign pop       = tok_valid && !tok_stall;
  assign wr_plus   = wr + QPTR_W'(1);
  assign level_in  = count + QCNT_W'(pair.count);
  assign full      = count > QCNT_W'(QUEUE_DEPTH - 2);
  assign tok_valid = count != '0;
  assign tok_data  = slot[rd];
  assign last_lo   = pair.item[0].last_result;
  assign last_hi   = pair.item[1].last_result;

  // write new results at the tail
  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) slot[wr] <= pair.item[0];
    if (pair.count == 2'd2) slot[wr_plus] <= pair.item[1];
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      rd    <= rd + QPTR_W'(pop);
      wr    <= wr + QPTR_W'(pair.count);
      count <= level_in - QCNT_W'(pop);
    end
  end

  `AET_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "result queue overfilled")
  `AET_ASSERT(a_no_overrun, level_in <= QCNT_W'(QUEUE_DEPTH) + QCNT_W'(pop), "queue overrun")
  `AET_ASSERT(a_pair_last, pair.count == 2'd2 |-> !last_lo && last_hi, "last mark misplaced")
  `AET_ASSERT(a_single_last, pair.count == 2'd1 |-> last_lo, "single result not marked last")
  `AET_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0 && !tok_valid, "queue not empty")

endmodule

[src/acl_expression_tokenizer.sv]
// ----------------------------------------------------------------------------
// acl_expression_tokenizer
// Filter-expression tokenizer: one character per transfer in, tokens,
// string content characters and errors out.
//
//   channel  direction  handshake              payload
//   char     in         char_valid/char_stall  char_data (char_item_t)
//   tok      out        tok_valid/tok_stall    tok_data  (tok_item_t)
//
// One character or terminator is taken per cycle while char_stall is low;
// its results land in the result queue at the edge that takes it.
// An item gives at most two results; the queue drains one per cycle without
// tok_stall, so sustained rate is one item per cycle for one result or fewer.
// char_stall rises while the four-entry queue has fewer than two free slots.
// Synchronous reset clears lexer state and empties the queue.
// ----------------------------------------------------------------------------
module acl_expression_tokenizer #(
  parameter int POS_BITS = aet_pkg::POS_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  aet_pkg::char_item_t char_data,
  output logic                tok_valid,
  input  logic                tok_stall,
  output aet_pkg::tok_item_t  tok_data
);
  import aet_pkg::*;

  res_pair_t pair;
  logic      accept;

  // take a character whenever the queue has room for two results
  assign accept = char_valid && !char_stall;

  aet_lex_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (char_data),
    .pair   (pair)
  );

  aet_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .full      (char_stall),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

endmodule
